// ===== rtl/ctb_pkg.sv =====
// Shared constants, register codes and the queued-operation type for the
// commutation transpose buffer. No dependencies.
package ctb_pkg;

   localparam int MAX_DIM     = 64;
   localparam int STORE_DEPTH = 4096;
   localparam int DATA_W      = 64;
   localparam int CNT_W       = $clog2(MAX_DIM);
   localparam int DIM_W       = CNT_W + 1;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int PTR_W       = $clog2(MAX_DIM * MAX_DIM);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;
   localparam int CSR_IDX_W   = 2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_COUNT      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TRANSPOSE_MODE = 2'd2;

   // request function codes
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   typedef struct packed {
      logic              is_load;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] data;
      logic              last;
   } ctb_op_type;

endpackage

// ===== rtl/ctb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ctb_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/ctb_front.sv =====
// Front end: configuration registers, load pointer, output counters and
// store address generation. Depends on ctb_pkg.
module ctb_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ctb_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ctb_pkg::DIM_W-1:0]          csr_wdata,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_func,
   input  logic [ctb_pkg::DATA_W-1:0]         req_element_bits,
   input  logic                               q_full,
   output logic                               push_valid,
   output ctb_pkg::ctb_op_type                push_op
);
   import ctb_pkg::*;

   logic [DIM_W-1:0] row_count_ff, row_count_in;
   logic [DIM_W-1:0] col_count_ff, col_count_in;
   logic             transpose_ff, transpose_in;
   logic [PTR_W-1:0] load_ptr_ff, load_ptr_in;
   logic [CNT_W-1:0] major_ff, major_in;
   logic [CNT_W-1:0] minor_ff, minor_in;

   logic [DIM_W-1:0]       rows, cols, major_lim, minor_lim;
   logic [2*DIM_W-1:0]     total;
   logic [2*DIM_W-1:0]     ptr_next;
   logic [CNT_W+DIM_W:0]   rd_addr_full;
   logic [DIM_W-1:0]       major_next, minor_next;
   logic                   major_wrap, minor_wrap;
   logic                   accept;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > DIM_W'(MAX_DIM)) begin
         r = DIM_W'(MAX_DIM);
      end else begin
         r = v;
      end
      return r;
   endfunction

   assign csr_ready = 1'b1;
   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   always_comb begin
      row_count_in = row_count_ff;
      col_count_in = col_count_ff;
      transpose_in = transpose_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_ROW_COUNT:      row_count_in = csr_wdata;
            CSR_COL_COUNT:      col_count_in = csr_wdata;
            CSR_TRANSPOSE_MODE: transpose_in = csr_wdata[0];
            default:            ;
         endcase
      end
   end

   always_comb begin
      rows      = clamp_dim(row_count_ff);
      cols      = clamp_dim(col_count_ff);
      total     = rows * cols;
      major_lim = transpose_ff ? cols : rows;
      minor_lim = transpose_ff ? rows : cols;

      ptr_next   = (2*DIM_W)'(load_ptr_ff) + (2*DIM_W)'(1);
      major_next = {1'b0, major_ff} + DIM_W'(1);
      minor_next = {1'b0, minor_ff} + DIM_W'(1);
      major_wrap = major_next >= major_lim;
      minor_wrap = minor_next >= minor_lim;

      // both modes reduce to major + minor * major_lim
      rd_addr_full = (CNT_W+DIM_W+1)'(minor_ff) * (CNT_W+DIM_W+1)'(major_lim)
                   + (CNT_W+DIM_W+1)'(major_ff);

      load_ptr_in = load_ptr_ff;
      major_in    = major_ff;
      minor_in    = minor_ff;
      if (accept) begin
         if (req_func == FUNC_LOAD) begin
            load_ptr_in = (ptr_next >= total) ? '0 : PTR_W'(ptr_next);
         end else if (minor_wrap) begin
            minor_in = '0;
            major_in = major_wrap ? '0 : CNT_W'(major_next);
         end else begin
            minor_in = CNT_W'(minor_next);
         end
      end

      push_valid      = accept;
      push_op.is_load = (req_func == FUNC_LOAD);
      push_op.addr    = (req_func == FUNC_LOAD) ? ADDR_W'(load_ptr_ff)
                                                : ADDR_W'(rd_addr_full);
      push_op.data    = req_element_bits;
      push_op.last    = major_wrap && minor_wrap;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= DIM_W'(1);
         col_count_ff <= DIM_W'(1);
         transpose_ff <= 1'b0;
         load_ptr_ff  <= '0;
         major_ff     <= '0;
         minor_ff     <= '0;
      end else begin
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
         transpose_ff <= transpose_in;
         load_ptr_ff  <= load_ptr_in;
         major_ff     <= major_in;
         minor_ff     <= minor_in;
      end
   end

endmodule

// ===== rtl/ctb_queue.sv =====
// Short in-order queue of decoded operations between front and back end.
// Depends on ctb_pkg.
module ctb_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  ctb_pkg::ctb_op_type push_op,
   output logic                full,
   output logic                pop_valid,
   output ctb_pkg::ctb_op_type pop_op,
   input  logic                pop
);
   import ctb_pkg::*;

   ctb_op_type        entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_op    = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/ctb_back.sv =====
// Back end: executes queued loads and reads on the element store and
// holds read results for the response channel. Depends on ctb_pkg, ctb_ram.
module ctb_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_valid,
   input  ctb_pkg::ctb_op_type         q_op,
   output logic                        q_pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [ctb_pkg::DATA_W-1:0]  rsp_result_bits,
   output logic                        rsp_is_last
);
   import ctb_pkg::*;

   logic              rd_pend_ff, rd_pend_in;
   logic              rd_last_ff, rd_last_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_bits_ff;
   logic              rsp_last_ff;
   logic [DATA_W-1:0] ram_rd_data;
   logic              move, can_read, wr_en, rd_en;

   // a read may issue when its data slot is free or drains this cycle
   assign move     = rd_pend_ff && (!rsp_valid_ff || !rsp_stall);
   assign can_read = !rd_pend_ff || move;
   assign wr_en    = q_valid && q_op.is_load;
   assign rd_en    = q_valid && !q_op.is_load && can_read;
   assign q_pop    = wr_en || rd_en;

   ctb_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (q_op.addr),
      .wr_data (q_op.data),
      .rd_en   (rd_en),
      .rd_addr (q_op.addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      rd_pend_in = rd_en ? 1'b1 : (move ? 1'b0 : rd_pend_ff);
      rd_last_in = rd_en ? q_op.last : rd_last_ff;
      if (move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_last_ff <= rd_last_in;
      if (move) begin
         rsp_bits_ff <= ram_rd_data;
         rsp_last_ff <= rd_last_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_bits = rsp_bits_ff;
   assign rsp_is_last     = rsp_last_ff;

endmodule

// ===== rtl/commutation_transpose_buffer.sv =====
// Commutation transpose buffer: loads a vectorised matrix, returns it permuted.
// Throughput: one request per cycle while req_stall is low (queue not full).
// A read request passes through the queue, the store read register and the response
// register before it shows on rsp; a load produces no response.
// Reset clears counters, pointers and configuration (1 x 1, normal mode); the element
// store keeps its contents and needs no clearing pass. Depends on ctb_pkg and submodules.
module commutation_transpose_buffer (
   input  logic                               clock,
   input  logic                               reset,
   // configuration write channel
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ctb_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ctb_pkg::DIM_W-1:0]          csr_wdata,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_func,
   input  logic [ctb_pkg::DATA_W-1:0]         req_element_bits,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [ctb_pkg::DATA_W-1:0]         rsp_result_bits,
   output logic                               rsp_is_last
);
   import ctb_pkg::*;

   // decoded request handed from front to queue
   logic       push_valid;
   ctb_op_type push_op;
   logic       q_full;

   // head of queue handed to the back end
   logic       q_valid;
   ctb_op_type q_op;
   logic       q_pop;

   // Front: take each request, advance the load pointer or the output
   // counters, and form the store address for it.
   ctb_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_element_bits (req_element_bits),
      .q_full           (q_full),
      .push_valid       (push_valid),
      .push_op          (push_op)
   );

   // Queue: hold decoded requests in order so a stalled response side
   // does not stall request acceptance straight away.
   ctb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_op    (push_op),
      .full       (q_full),
      .pop_valid  (q_valid),
      .pop_op     (q_op),
      .pop        (q_pop)
   );

   // Back: write loads into the store, read permuted elements and drive
   // the response register.
   ctb_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_op            (q_op),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_bits (rsp_result_bits),
      .rsp_is_last     (rsp_is_last)
   );

endmodule
